@@ sv/gbe_pkg.sv @@
// ----------------------------------------------------------------------------
// gbe_pkg - shared constants and sizing helpers for the glyph bounds extractor
// Grid geometry, register indexes, record codes and width helpers that follow
// from the largest cell size.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int GRID   = 16;
  localparam int GRID_W = 4;

  localparam int DEF_MAX_CELL_W = 64;
  localparam int DEF_MAX_CELL_H = 64;

  // Largest value a 7-bit size register can hold
  localparam int CFG_SIZE_MAX = 127;

  localparam logic [6:0] RST_CELL_WIDTH     = 7'd16;
  localparam logic [6:0] RST_CELL_HEIGHT    = 7'd16;
  localparam logic [7:0] RST_BASELINE_GLYPH = 8'd65;

  localparam logic [1:0] REG_CELL_WIDTH     = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_BASELINE_GLYPH = 2'd2;

  localparam logic RECORD_GLYPH   = 1'b0;
  localparam logic RECORD_METRICS = 1'b1;

  function automatic int size_cap(input int max_size);
    return (max_size < CFG_SIZE_MAX) ? max_size : CFG_SIZE_MAX;
  endfunction

  // bits to hold a clamped cell size
  function automatic int size_bits(input int max_size);
    return $clog2(size_cap(max_size) + 1);
  endfunction

  // bits to hold an in-cell position
  function automatic int pos_bits(input int max_size);
    return (size_cap(max_size) > 1) ? $clog2(size_cap(max_size)) : 1;
  endfunction

  // one band lane: found, right, left
  function automatic int lane_bits(input int max_w);
    return 1 + 2 * pos_bits(max_w);
  endfunction

  // band snapshot: row, last flag, min top, baseline row, cell width, lanes
  function automatic int queue_bits(input int max_w, input int max_h);
    return GRID * lane_bits(max_w) + GRID_W + 1 + 2 * size_bits(max_h) + size_bits(max_w);
  endfunction

endpackage

@@ sv/glyph_bounds_extractor.sv @@
// ----------------------------------------------------------------------------
// glyph_bounds_extractor - per-cell glyph bounds of a 16x16 glyph sheet
// Input queue: push a pixel while full is low, raster order, one per cycle.
// The first pixel of each sheet is taken as the background color.
// Result queue: while empty is low the oldest record is on the ports; pop
// takes it. At the last pixel of each band of cells, 16 glyph records follow
// (cell order); the last band adds one metrics record with last high.
// The first record of a band passes the band queue and the output register
// before it shows; records then leave one per cycle while pop is held high.
// Throughput: one pixel per cycle. A band ending while two band snapshots
// already wait raises full until the emitter frees one.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready. After each write full stays high while the load state and the
// position divider re-derive the cell position.
// Reset (rst, synchronous): registers return to 16x16 cells, baseline 'A',
// position at sheet start, both queues empty.
// A stalled receiver fills the output register, then the band queue, then
// raises full at the next band end; nothing is dropped.
// ----------------------------------------------------------------------------
module glyph_bounds_extractor #(
  parameter int MAX_CELL_W = gbe_pkg::DEF_MAX_CELL_W,
  parameter int MAX_CELL_H = gbe_pkg::DEF_MAX_CELL_H
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] pixel,
  input  logic        pop,
  output logic        empty,
  output logic        record_kind,
  output logic [7:0]  glyph_index,
  output logic [9:0]  glyph_left,
  output logic [6:0]  glyph_width,
  output logic [6:0]  line_top,
  output logic [6:0]  line_height,
  output logic [5:0]  space_width,
  output logic        last
);
  import gbe_pkg::*;

  localparam int DW = queue_bits(MAX_CELL_W, MAX_CELL_H);

  logic          q_push;
  logic [DW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic [DW-1:0] q_rdata;
  logic          q_empty;

  assign cfg_ready = 1'b1;

  gbe_front #(
    .MAX_CELL_W(MAX_CELL_W),
    .MAX_CELL_H(MAX_CELL_H)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .pixel     (pixel),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  gbe_band_queue #(
    .WIDTH(DW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  gbe_back #(
    .MAX_CELL_W(MAX_CELL_W),
    .MAX_CELL_H(MAX_CELL_H)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .record_kind (record_kind),
    .glyph_index (glyph_index),
    .glyph_left  (glyph_left),
    .glyph_width (glyph_width),
    .line_top    (line_top),
    .line_height (line_height),
    .space_width (space_width),
    .last        (last)
  );

endmodule

@@ sv/gbe_band_queue.sv @@
// ----------------------------------------------------------------------------
// gbe_band_queue - two-entry queue of band snapshots
// Parts the pixel scanner from the record emitter so each side stalls alone.
// ----------------------------------------------------------------------------
module gbe_band_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);
  logic [1:0][WIDTH-1:0] entries;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ sv/gbe_front.sv @@
// ----------------------------------------------------------------------------
// gbe_front - pixel scanner
// Holds configuration, walks the sheet position, tracks per-cell column bounds,
// top row and baseline row, and pushes a band snapshot at the end of each band.
// ----------------------------------------------------------------------------
module gbe_front #(
  parameter int MAX_CELL_W = gbe_pkg::DEF_MAX_CELL_W,
  parameter int MAX_CELL_H = gbe_pkg::DEF_MAX_CELL_H
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  input  logic [31:0] pixel,
  output logic        full,
  output logic        q_push,
  output logic [gbe_pkg::queue_bits(MAX_CELL_W, MAX_CELL_H)-1:0] q_data,
  input  logic        q_full
);
  import gbe_pkg::*;

  localparam int CW_MAX = size_cap(MAX_CELL_W);
  localparam int CH_MAX = size_cap(MAX_CELL_H);
  localparam int CWB    = size_bits(MAX_CELL_W);
  localparam int CHB    = size_bits(MAX_CELL_H);
  localparam int PCW    = pos_bits(MAX_CELL_W);
  localparam int CCW    = CWB + GRID_W;
  localparam int CRW    = CHB + GRID_W;
  localparam int LW     = lane_bits(MAX_CELL_W);

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;

  logic [6:0]  cell_width;
  logic [6:0]  cell_height;
  logic [7:0]  baseline_glyph;
  logic [1:0]  state;

  logic [31:0] background_color;
  logic [CCW-1:0] column_counter;
  logic [CRW-1:0] row_counter;
  logic [CCW-1:0] pc;
  logic [CRW-1:0] pr;
  logic [GRID_W-1:0] c;
  logic [GRID_W-1:0] r;

  logic [GRID-1:0]           band_found;
  logic [GRID-1:0][PCW-1:0]  band_left;
  logic [GRID-1:0][PCW-1:0]  band_right;
  logic [CHB-1:0]            min_top;
  logic [CHB-1:0]            baseline_row;

  logic [CWB-1:0] cw_e;
  logic [CHB-1:0] ch_e;
  logic           first;
  logic           hit;
  logic           f0;
  logic [PCW-1:0] l0;
  logic [PCW-1:0] r0;
  logic [PCW-1:0] pcs;
  logic [CHB-1:0] prs;
  logic           lane_found_next;
  logic [PCW-1:0] lane_left_next;
  logic [PCW-1:0] lane_right_next;
  logic [CHB-1:0] mt0;
  logic [CHB-1:0] min_top_next;
  logic [CHB-1:0] bl0;
  logic [CHB-1:0] baseline_row_next;
  logic           is_base;
  logic           col_last;
  logic           row_last;
  logic           band_end;
  logic           sheet_end;
  logic           accept;
  logic           cfg_write;
  logic           out_of_sheet;
  logic [GRID-1:0][LW-1:0] snap;

  // Clamp sizes: zero acts as one, large values saturate
  always_comb begin
    if (cell_width == 7'd0) begin
      cw_e = CWB'(1);
    end else if (cell_width > 7'(CW_MAX)) begin
      cw_e = CWB'(CW_MAX);
    end else begin
      cw_e = CWB'(cell_width);
    end
    if (cell_height == 7'd0) begin
      ch_e = CHB'(1);
    end else if (cell_height > 7'(CH_MAX)) begin
      ch_e = CHB'(CH_MAX);
    end else begin
      ch_e = CHB'(cell_height);
    end
  end

  assign cfg_write = cfg_valid;
  assign first     = (column_counter == '0) && (row_counter == '0);
  assign hit       = !first && (pixel != background_color);
  assign pcs       = pc[PCW-1:0];
  assign prs       = pr[CHB-1:0];

  always_comb begin
    f0 = first ? 1'b0 : band_found[c];
    l0 = first ? '0 : band_left[c];
    r0 = first ? '0 : band_right[c];
    lane_found_next = f0 | hit;
    lane_left_next  = l0;
    lane_right_next = r0;
    if (hit) begin
      if (!f0 || pcs < l0) begin
        lane_left_next = pcs;
      end
      if (!f0 || pcs > r0) begin
        lane_right_next = pcs;
      end
    end
    mt0 = first ? ch_e : min_top;
    min_top_next = (hit && prs < mt0) ? prs : mt0;
    bl0 = first ? ch_e : baseline_row;
    is_base = ({r, c} == baseline_glyph);
    baseline_row_next = bl0;
    if (hit && is_base && (bl0 >= ch_e || prs > bl0)) begin
      baseline_row_next = prs;
    end
  end

  assign col_last  = (c == GRID_W'(GRID - 1)) && (pc == CCW'(cw_e - 1'b1));
  assign row_last  = (pr == CRW'(ch_e - 1'b1));
  assign band_end  = col_last && row_last;
  assign sheet_end = band_end && (r == GRID_W'(GRID - 1));

  assign full   = (state != ST_RUN) || (band_end && q_full);
  assign accept = push && !full;
  assign q_push = accept && band_end;

  always_comb begin
    for (int i = 0; i < GRID; i++) begin
      if (GRID_W'(i) == c) begin
        snap[i] = {lane_found_next, lane_right_next, lane_left_next};
      end else if (first) begin
        snap[i] = '0;
      end else begin
        snap[i] = {band_found[i], band_right[i], band_left[i]};
      end
    end
  end

  assign q_data = {r, sheet_end, min_top_next, baseline_row_next, cw_e, snap};

  assign out_of_sheet = (column_counter >= {cw_e, GRID_W'(0)}) ||
                        (row_counter >= {ch_e, GRID_W'(0)});

  always_ff @(posedge clk) begin
    if (accept) begin
      if (first) begin
        background_color <= pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width     <= RST_CELL_WIDTH;
      cell_height    <= RST_CELL_HEIGHT;
      baseline_glyph <= RST_BASELINE_GLYPH;
      state          <= ST_RUN;
      column_counter <= '0;
      row_counter    <= '0;
      pc             <= '0;
      pr             <= '0;
      c              <= '0;
      r              <= '0;
      band_found     <= '0;
      band_left      <= '0;
      band_right     <= '0;
      min_top        <= CHB'(size_cap(16) < CH_MAX ? 16 : CH_MAX);
      baseline_row   <= CHB'(size_cap(16) < CH_MAX ? 16 : CH_MAX);
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CELL_WIDTH:     cell_width     <= cfg_data[6:0];
          REG_CELL_HEIGHT:    cell_height    <= cfg_data[6:0];
          REG_BASELINE_GLYPH: baseline_glyph <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_LOAD: begin
          // drop the position if it fell outside the resized sheet
          if (out_of_sheet) begin
            column_counter <= '0;
            row_counter    <= '0;
            pc             <= '0;
            pr             <= '0;
          end else begin
            pc <= column_counter;
            pr <= row_counter;
          end
          c <= '0;
          r <= '0;
        end
        ST_DIVIDE: begin
          // split the position into cell and in-cell parts by subtraction
          if (pc >= CCW'(cw_e)) begin
            pc <= pc - CCW'(cw_e);
            c  <= c + 1'b1;
          end
          if (pr >= CRW'(ch_e)) begin
            pr <= pr - CRW'(ch_e);
            r  <= r + 1'b1;
          end
        end
        default: begin
          if (accept) begin
            min_top      <= min_top_next;
            baseline_row <= baseline_row_next;
            if (band_end) begin
              band_found <= '0;
              band_left  <= '0;
              band_right <= '0;
            end else begin
              for (int i = 0; i < GRID; i++) begin
                {band_found[i], band_right[i], band_left[i]} <= snap[i];
              end
            end
            if (col_last) begin
              column_counter <= '0;
              pc             <= '0;
              c              <= '0;
              if (row_last) begin
                pr <= '0;
                r  <= r + 1'b1;
              end else begin
                pr <= pr + 1'b1;
              end
              if (sheet_end) begin
                row_counter <= '0;
              end else begin
                row_counter <= row_counter + 1'b1;
              end
            end else begin
              column_counter <= column_counter + 1'b1;
              if (pc == CCW'(cw_e - 1'b1)) begin
                pc <= '0;
                c  <= c + 1'b1;
              end else begin
                pc <= pc + 1'b1;
              end
            end
          end
        end
      endcase

      if (cfg_write) begin
        state <= ST_LOAD;
      end else if (state == ST_LOAD) begin
        state <= ST_DIVIDE;
      end else if (state == ST_DIVIDE) begin
        if (pc < CCW'(cw_e) && pr < CRW'(ch_e)) begin
          state <= ST_RUN;
        end
      end
    end
  end

endmodule

@@ sv/gbe_back.sv @@
// ----------------------------------------------------------------------------
// gbe_back - record emitter
// Walks one band snapshot lane by lane into the output register, one record a
// cycle while it is empty or popped, and adds the metrics record after a sheet's final band.
// ----------------------------------------------------------------------------
module gbe_back #(
  parameter int MAX_CELL_W = gbe_pkg::DEF_MAX_CELL_W,
  parameter int MAX_CELL_H = gbe_pkg::DEF_MAX_CELL_H
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [gbe_pkg::queue_bits(MAX_CELL_W, MAX_CELL_H)-1:0] q_data,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic       record_kind,
  output logic [7:0] glyph_index,
  output logic [9:0] glyph_left,
  output logic [6:0] glyph_width,
  output logic [6:0] line_top,
  output logic [6:0] line_height,
  output logic [5:0] space_width,
  output logic       last
);
  import gbe_pkg::*;

  localparam int CWB = size_bits(MAX_CELL_W);
  localparam int CHB = size_bits(MAX_CELL_H);
  localparam int PCW = pos_bits(MAX_CELL_W);
  localparam int CCW = CWB + GRID_W;
  localparam int LW  = lane_bits(MAX_CELL_W);

  logic [GRID-1:0][LW-1:0] lanes;
  logic [GRID_W-1:0]       band_row;
  logic                    band_last;
  logic [CHB-1:0]          mt;
  logic [CHB-1:0]          base;
  logic [CWB-1:0]          cw;

  logic [GRID_W:0]   idx;
  logic [CCW-1:0]    left_base;
  logic              out_valid;

  logic [LW-1:0]     lane;
  logic [PCW-1:0]    lane_left;
  logic [PCW-1:0]    lane_right;
  logic              lane_found;
  logic              metrics_now;
  logic              lane_end;
  logic              advance;
  logic [CHB-1:0]    lh;

  assign {band_row, band_last, mt, base, cw, lanes} = q_data;

  assign lane        = lanes[idx[GRID_W-1:0]];
  assign lane_left   = lane[PCW-1:0];
  assign lane_right  = lane[2*PCW-1:PCW];
  assign lane_found  = lane[2*PCW];
  assign metrics_now = idx[GRID_W];
  assign lane_end    = (idx == (GRID_W+1)'(GRID - 1));
  assign lh          = (base >= mt) ? (base - mt) : '0;

  assign empty   = !out_valid;
  assign advance = !q_empty && (!out_valid || pop);
  assign q_pop   = advance && (metrics_now || (lane_end && !band_last));

  always_ff @(posedge clk) begin
    if (advance) begin
      if (metrics_now) begin
        record_kind <= RECORD_METRICS;
        glyph_index <= '0;
        glyph_left  <= '0;
        glyph_width <= '0;
        line_top    <= 7'(mt);
        line_height <= 7'(lh);
        space_width <= 6'(cw >> 1);
        last        <= 1'b1;
      end else begin
        record_kind <= RECORD_GLYPH;
        glyph_index <= {band_row, idx[GRID_W-1:0]};
        if (lane_found) begin
          glyph_left  <= 10'(left_base + CCW'(lane_left));
          glyph_width <= 7'(CWB'(lane_right) - CWB'(lane_left) + CWB'(1));
        end else begin
          glyph_left  <= 10'(left_base);
          glyph_width <= 7'(cw);
        end
        line_top    <= '0;
        line_height <= '0;
        space_width <= '0;
        last        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      left_base <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (metrics_now) begin
          idx       <= '0;
          left_base <= '0;
        end else if (lane_end) begin
          // hold for the metrics record on the final band
          idx       <= band_last ? (GRID_W+1)'(GRID) : '0;
          left_base <= '0;
        end else begin
          idx       <= idx + 1'b1;
          left_base <= left_base + CCW'(cw);
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
